// ===== design/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the IR pulse-distance frame encoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int FRAME_BITS_DEF = 32;
  localparam int WORD_W         = 32;
  localparam int TICK_W         = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [TICK_W-1:0] START_ON_RST  = 16'd4500;
  localparam logic [TICK_W-1:0] START_OFF_RST = 16'd4500;
  localparam logic [TICK_W-1:0] ONE_ON_RST    = 16'd560;
  localparam logic [TICK_W-1:0] ONE_OFF_RST   = 16'd1690;
  localparam logic [TICK_W-1:0] ZERO_ON_RST   = 16'd560;
  localparam logic [TICK_W-1:0] ZERO_OFF_RST  = 16'd560;

  localparam logic [CFG_IDX_W-1:0] REG_START_ON  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_ON    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_OFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_ON   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFF  = 3'd5;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_SEND = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START_ON  = 3'd1,
    PH_START_OFF = 3'd2,
    PH_BIT_ON    = 3'd3,
    PH_BIT_OFF   = 3'd4,
    PH_STOP_ON   = 3'd5,
    PH_STOP_OFF  = 3'd6
  } phase_t;

endpackage

// ===== design/ir_pulse_distance_frame_encoder_core.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_encoder_core
// Carrier-enable envelope generator for one pulse-distance IR frame.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects a timing tick (0) or a send request (1);
// in_tdata carries the frame word, taken only by a send request while idle.
// Every accepted request produces exactly one result in the following cycle on the
// output stream: envelope level and busy flag in out_tdata, and out_tlast
// high on the tick that ends the stop gap of a frame.
// A frame is a start pulse and gap, FRAME_BITS data bits lsb first, then a
// stop pulse and gap; each phase lasts its configured count of ticks.
// Throughput is one request per clock while the receiver does not stall: the
// phase/count update is a single increment and compare in front of the result register.
// When the receiver stalls, the held result keeps in_tready low until it is
// taken; in_tready stays high while the result register is empty or drains.
// Reset (rst_n low, synchronous) returns the block to idle, empties the
// result register and loads the default tick counts. Configuration writes via
// cfg_wen/cfg_addr/cfg_wdata take effect at the next clock edge.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_encoder_core #(
  parameter int FRAME_BITS = irpd_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [irpd_pkg::WORD_W-1:0]      in_tdata,   // frame_word
  input  logic                             in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // envelope, busy_res, zeros
  output logic                             out_tlast,  // frame_done
  input  logic                             cfg_wen,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [irpd_pkg::TICK_W-1:0]      cfg_wdata
);
  import irpd_pkg::*;

  localparam int BPW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [BPW-1:0] LAST_BIT = BPW'(FRAME_BITS - 1);

  logic [TICK_W-1:0] start_on_r, start_off_r, one_on_r, one_off_r;
  logic [TICK_W-1:0] zero_on_r, zero_off_r;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] cnt_r, cnt_nxt;
  logic [BPW-1:0]    bitpos_r, bitpos_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;

  logic              out_valid_r;
  logic              env_r, env_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic              accept;
  logic [TICK_W-1:0] len;
  logic [TICK_W:0]   cnt_inc;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, busy_r, env_r};
  assign out_tlast  = done_r;
  assign cnt_inc    = {1'b0, cnt_r} + {{TICK_W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_on_r  <= START_ON_RST;
      start_off_r <= START_OFF_RST;
      one_on_r    <= ONE_ON_RST;
      one_off_r   <= ONE_OFF_RST;
      zero_on_r   <= ZERO_ON_RST;
      zero_off_r  <= ZERO_OFF_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_START_ON:  start_on_r  <= cfg_wdata;
        REG_START_OFF: start_off_r <= cfg_wdata;
        REG_ONE_ON:    one_on_r    <= cfg_wdata;
        REG_ONE_OFF:   one_off_r   <= cfg_wdata;
        REG_ZERO_ON:   zero_on_r   <= cfg_wdata;
        REG_ZERO_OFF:  zero_off_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (phase_r)
      PH_START_ON:  len = start_on_r;
      PH_START_OFF: len = start_off_r;
      PH_BIT_ON:    len = shift_r[0] ? one_on_r : zero_on_r;
      PH_BIT_OFF:   len = shift_r[0] ? one_off_r : zero_off_r;
      PH_STOP_ON:   len = zero_on_r;
      PH_STOP_OFF:  len = zero_off_r;
      default:      len = TICK_W'(1);
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    bitpos_nxt = bitpos_r;
    shift_nxt  = shift_r;
    done_nxt   = 1'b0;
    if (in_tuser == KIND_SEND) begin
      if (phase_r == PH_IDLE) begin
        shift_nxt  = in_tdata;
        bitpos_nxt = '0;
        cnt_nxt    = '0;
        phase_nxt  = PH_START_ON;
      end
    end else if (phase_r != PH_IDLE) begin
      if (cnt_inc < {1'b0, len}) begin
        cnt_nxt = cnt_inc[TICK_W-1:0];
      end else begin
        cnt_nxt = '0;
        unique case (phase_r)
          PH_START_ON:  phase_nxt = PH_START_OFF;
          PH_START_OFF: phase_nxt = PH_BIT_ON;
          PH_BIT_ON:    phase_nxt = PH_BIT_OFF;
          PH_BIT_OFF: begin
            shift_nxt = {1'b0, shift_r[WORD_W-1:1]};
            if (bitpos_r == LAST_BIT) begin
              bitpos_nxt = '0;
              phase_nxt  = PH_STOP_ON;
            end else begin
              bitpos_nxt = bitpos_r + BPW'(1);
              phase_nxt  = PH_BIT_ON;
            end
          end
          PH_STOP_ON:   phase_nxt = PH_STOP_OFF;
          PH_STOP_OFF: begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
          default:      phase_nxt = PH_IDLE;
        endcase
      end
    end
    env_nxt  = (phase_nxt == PH_START_ON) || (phase_nxt == PH_BIT_ON) ||
               (phase_nxt == PH_STOP_ON);
    busy_nxt = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      bitpos_r <= '0;
      shift_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      bitpos_r <= bitpos_nxt;
      shift_r  <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      env_r  <= env_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
